@@ rtl/kvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key/value table package
// Field widths, opcodes, status codes and parameter defaults shared by the
// key/value table RTL.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int FIELD_W     = 32;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 5;

  localparam int DEPTH_DEF       = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } kvt_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_DELETED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } kvt_status_t;

endpackage : kvt_pkg
`default_nettype wire

@@ rtl/key_value_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key/value table unit
// Fixed-capacity table of key/value entries with insert-or-update, delete,
// lookup and clear, and a status word for every command word.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   -------   --------------   ------------------------------------------
//   input     start / busy     in_opcode, in_key, in_value
//   result    out_valid        out_status, out_value_out, out_entry_count,
//                              out_is_empty
//
// A command word is accepted on any edge with start high; busy stays low, so
// one word is taken every cycle. The word is registered, then matched against
// all entries in parallel, and its result is registered in the result
// register, which holds it on the result ports for exactly one cycle. The
// table update lands on the edge that registers the result, so the following
// word already sees it.
// Synchronous reset empties the table (valid bits and count); stored keys and
// values are not cleared. The receiver cannot stall the result channel.
// ----------------------------------------------------------------------------
module key_value_table_unit #(
  parameter int DEPTH       = kvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [kvt_pkg::OPCODE_W-1:0]      in_opcode,
  input  wire logic [kvt_pkg::FIELD_W-1:0]       in_key,
  input  wire logic [kvt_pkg::FIELD_W-1:0]       in_value,
  output      logic                              out_valid,
  output      logic [kvt_pkg::STATUS_W-1:0]      out_status,
  output      logic [kvt_pkg::FIELD_W-1:0]       out_value_out,
  output      logic [kvt_pkg::COUNT_OUT_W-1:0]   out_entry_count,
  output      logic                              out_is_empty
);
  import kvt_pkg::*;

  // Only the bits that survive both the port and the parameter are kept.
  localparam int KEY_KEEP = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
  localparam int VAL_KEEP = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Input register.
  logic                in_vld_r;
  kvt_op_t             op_r;
  logic [KEY_KEEP-1:0] key_r;
  logic [VAL_KEEP-1:0] value_r;

  // Table storage.
  logic [KEY_KEEP-1:0] key_store [DEPTH];
  logic [VAL_KEEP-1:0] value_store [DEPTH];
  logic [DEPTH-1:0]    valid_r, valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  // Result register.
  logic                out_valid_r;
  kvt_status_t         status_r, status_nxt;
  logic [VAL_KEEP-1:0] vout_r, vout_nxt;
  logic [CNT_W-1:0]    count_out_r;

  // Match and allocation search.
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                free_any;
  logic [IDX_W-1:0]    free_idx;
  logic                wr_key;
  logic                wr_val;
  logic [IDX_W-1:0]    wr_idx;

  assign busy = 1'b0;

  // Descending scan so that the lowest matching or free slot wins.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_store[i] == key_r)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    status_nxt = ST_NOT_FOUND;
    vout_nxt   = '0;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    wr_idx     = hit_idx;
    unique case (op_r)
      OP_INSERT: begin
        if (hit) begin
          wr_val     = 1'b1;
          status_nxt = ST_UPDATED;
        end else if (!free_any || (count_r >= CNT_W'(DEPTH))) begin
          status_nxt = ST_FULL;
        end else begin
          wr_key              = 1'b1;
          wr_val              = 1'b1;
          wr_idx              = free_idx;
          valid_nxt[free_idx] = 1'b1;
          count_nxt           = count_r + CNT_W'(1);
          status_nxt          = ST_ADDED;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          valid_nxt[hit_idx] = 1'b0;
          if (count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
          status_nxt = ST_DELETED;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          vout_nxt   = value_store[hit_idx];
          status_nxt = ST_FOUND;
        end
      end
      OP_CLEAR: begin
        valid_nxt  = '0;
        count_nxt  = '0;
        status_nxt = ST_CLEARED;
      end
      default: begin
        status_nxt = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
    end else begin
      in_vld_r    <= start && !busy;
      out_valid_r <= in_vld_r;
      if (in_vld_r) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers and table contents need no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r    <= kvt_op_t'(in_opcode);
      key_r   <= in_key[KEY_KEEP-1:0];
      value_r <= in_value[VAL_KEEP-1:0];
    end
    if (in_vld_r) begin
      status_r    <= status_nxt;
      vout_r      <= vout_nxt;
      count_out_r <= count_nxt;
      if (wr_key) begin
        key_store[wr_idx] <= key_r;
      end
      if (wr_val) begin
        value_store[wr_idx] <= value_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value_out   = FIELD_W'(vout_r);
  assign out_entry_count = COUNT_OUT_W'(count_out_r);
  assign out_is_empty    = (count_out_r == '0);

endmodule : key_value_table_unit
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table unit testbench
// Sends insert, delete, lookup and clear command words with random spacing.
// A scoreboard keeps its own copy of the table, predicts the status, value,
// entry count and empty flag for every accepted command and checks each result strobe against it in order.
// ----------------------------------------------------------------------------

typedef struct {
  kvt_pkg::kvt_status_t status;
  logic [31:0]          value;
  logic [4:0]           count;
  logic                 empty;
} table_result_t;

class table_scoreboard;
  localparam int SLOTS = kvt_pkg::DEPTH_DEF;

  logic [31:0]   slot_key [SLOTS];
  logic [31:0]   slot_value [SLOTS];
  bit            slot_used [SLOTS];
  int unsigned   used_count;
  table_result_t expected_q[$];
  int unsigned   errors;

  task report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Works out the result of one accepted command word and updates the table.
  function void note_command(input kvt_pkg::kvt_op_t op, input logic [31:0] key,
                             input logic [31:0] value);
    table_result_t res;
    int hit;
    int free;
    hit  = -1;
    free = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) hit = i;
      if (!slot_used[i]) free = i;
    end
    res.value = '0;
    case (op)
      kvt_pkg::OP_INSERT: begin
        if (hit >= 0) begin
          slot_value[hit] = value;
          res.status = kvt_pkg::ST_UPDATED;
        end else if (free < 0 || used_count >= SLOTS) begin
          res.status = kvt_pkg::ST_FULL;
        end else begin
          slot_key[free]   = key;
          slot_value[free] = value;
          slot_used[free]  = 1'b1;
          used_count++;
          res.status = kvt_pkg::ST_ADDED;
        end
      end
      kvt_pkg::OP_DELETE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          used_count--;
          res.status = kvt_pkg::ST_DELETED;
        end else begin
          res.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      kvt_pkg::OP_LOOKUP: begin
        if (hit >= 0) begin
          res.value  = slot_value[hit];
          res.status = kvt_pkg::ST_FOUND;
        end else begin
          res.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        used_count = 0;
        res.status = kvt_pkg::ST_CLEARED;
      end
    endcase
    res.count = used_count[4:0];
    res.empty = (used_count == 0);
    expected_q.push_back(res);
  endfunction

  task check_result(input logic [2:0] status, input logic [31:0] value,
                    input logic [4:0] count, input logic empty);
    table_result_t res;
    if (expected_q.size() == 0) begin
      report_mismatch("result word with no command outstanding");
    end else begin
      res = expected_q.pop_front();
      if (status !== res.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, res.status));
      if (value !== res.value)
        report_mismatch($sformatf("value %h, expected %h", value, res.value));
      if (count !== res.count)
        report_mismatch($sformatf("entry count %0d, expected %0d", count, res.count));
      if (empty !== res.empty)
        report_mismatch($sformatf("empty flag %b, expected %b", empty, res.empty));
    end
  endtask
endclass

module testbench;
  localparam int RANDOM_WORDS = 1650;
  localparam int POOL_MAX     = 24;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_value_out;
  logic [4:0]  out_entry_count;
  logic        out_is_empty;

  table_scoreboard sb = new();
  bit              no_gaps;
  logic [31:0]     key_pool [POOL_MAX];
  int              pool_size;

  key_value_table_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_value_out, out_entry_count, out_is_empty);
  end

  // Entered and left at a falling edge; waits until the word is taken.
  task automatic send_command(input kvt_pkg::kvt_op_t op, input logic [31:0] key,
                              input logic [31:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    in_opcode = op;
    in_key    = key;
    in_value  = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, key, value);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    // Near misses differ from a pool key in a single bit.
    if (r < 93)
      return key_pool[$urandom_range(0, pool_size - 1)] ^
             (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  function automatic kvt_pkg::kvt_op_t pick_op();
    int r;
    r = $urandom_range(0, 199);
    if (r < 90)  return kvt_pkg::OP_INSERT;
    if (r < 130) return kvt_pkg::OP_DELETE;
    if (r < 197) return kvt_pkg::OP_LOOKUP;
    return kvt_pkg::OP_CLEAR;
  endfunction

  initial begin
    int wait_cycles;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_opcode = kvt_pkg::OP_INSERT;
    in_key    = '0;
    in_value  = '0;
    no_gaps   = 1'b0;
    pool_size = POOL_MAX;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: empty table, extreme keys and values, fill, full, reuse.
    send_command(kvt_pkg::OP_LOOKUP, 32'h0000_0000, $urandom);
    send_command(kvt_pkg::OP_DELETE, 32'h0000_0005, $urandom);
    send_command(kvt_pkg::OP_CLEAR,  $urandom, $urandom);
    send_command(kvt_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_command(kvt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(kvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(kvt_pkg::OP_INSERT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_command(kvt_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    for (int i = 2; i < kvt_pkg::DEPTH_DEF; i++)
      send_command(kvt_pkg::OP_INSERT, 32'h1000_0000 + i, ~i);
    send_command(kvt_pkg::OP_INSERT, 32'hDEAD_BEEF, 32'h1234_5678);
    send_command(kvt_pkg::OP_INSERT, 32'h0000_0000, 32'h8765_4321);
    send_command(kvt_pkg::OP_DELETE, 32'hFFFF_FFFF, $urandom);
    send_command(kvt_pkg::OP_INSERT, 32'h8000_0001, 32'hCAFE_F00D);
    send_command(kvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, $urandom);
    send_command(kvt_pkg::OP_LOOKUP, 32'h8000_0001, $urandom);
    send_command(kvt_pkg::OP_CLEAR,  $urandom, $urandom);

    // Random part: keys mostly come from a small pool so that hits, updates
    // and a full table are common; the pool changes from segment to segment.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0) begin
        pool_size = $urandom_range(6, POOL_MAX);
        for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
      end
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_command(pick_op(), pick_key(), $urandom);
    end
    start = 1'b0;

    wait_cycles = 0;
    while (sb.expected_q.size() != 0 && wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));

    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
